/* src/ptsu_pkg.sv */
// Shared types, constants and microprogram for the prime test and search unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package ptsu_pkg;

   // default operand width
   localparam int VALUE_WIDTH_DEF = 32;

   // step counter width and microprogram addresses
   localparam int STEP_W = 5;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type ST_FETCH     = 5'd0;
   localparam step_type ST_CHK_LT2   = 5'd1;
   localparam step_type ST_CHK_TWO   = 5'd2;
   localparam step_type ST_CHK_EVEN  = 5'd3;
   localparam step_type ST_D_INIT    = 5'd4;
   localparam step_type ST_DIV_GO    = 5'd5;
   localparam step_type ST_DIV_WAIT  = 5'd6;
   localparam step_type ST_CHK_BOUND = 5'd7;
   localparam step_type ST_CHK_REM   = 5'd8;
   localparam step_type ST_D_NEXT    = 5'd9;
   localparam step_type ST_PRIME     = 5'd10;
   localparam step_type ST_NOTPRIME  = 5'd11;
   localparam step_type ST_SRCH_END  = 5'd12;
   localparam step_type ST_C_DEC     = 5'd13;
   localparam step_type ST_SET_ONE   = 5'd14;
   localparam step_type ST_OUT_WAIT  = 5'd15;
   localparam step_type ST_EMIT      = 5'd16;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_D_INIT,
      OP_DIV_GO,
      OP_D_ADD2,
      OP_PF_SET,
      OP_PF_CLR,
      OP_C_DEC,
      OP_C_ONE,
      OP_EMIT
   } op_type;

   // jump conditions
   typedef enum logic [3:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_NO_REQ,
      CND_C_LT2,
      CND_C_IS2,
      CND_C_EVEN,
      CND_DIV_BUSY,
      CND_D_GT_Q,
      CND_R_ZERO,
      CND_IS_TEST,
      CND_OUT_FULL
   } cond_type;

   // one control word
   typedef struct packed {
      logic     in_ready;
      op_type   op;
      cond_type cond;
      step_type target;
   } cword_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic req_valid;
      logic c_lt2;
      logic c_is2;
      logic c_even;
      logic div_busy;
      logic d_gt_q;
      logic r_zero;
      logic is_test;
      logic out_full;
   } status_type;

   // request kinds
   localparam logic REQ_TEST   = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   // microprogram ROM
   function automatic cword_type ucode_rom(input step_type step);
      cword_type w;
      w = '{in_ready: 1'b0, op: OP_NOP, cond: CND_ALWAYS, target: ST_FETCH};
      case (step)
         ST_FETCH: begin
            w = '{in_ready: 1'b1, op: OP_LOAD, cond: CND_NO_REQ, target: ST_FETCH};
         end
         ST_CHK_LT2: begin
            w = '{in_ready: 1'b0, op: OP_NOP, cond: CND_C_LT2, target: ST_NOTPRIME};
         end
         ST_CHK_TWO: begin
            w = '{in_ready: 1'b0, op: OP_NOP, cond: CND_C_IS2, target: ST_PRIME};
         end
         ST_CHK_EVEN: begin
            w = '{in_ready: 1'b0, op: OP_NOP, cond: CND_C_EVEN, target: ST_NOTPRIME};
         end
         ST_D_INIT: begin
            w = '{in_ready: 1'b0, op: OP_D_INIT, cond: CND_NEVER, target: ST_FETCH};
         end
         ST_DIV_GO: begin
            w = '{in_ready: 1'b0, op: OP_DIV_GO, cond: CND_NEVER, target: ST_FETCH};
         end
         ST_DIV_WAIT: begin
            w = '{in_ready: 1'b0, op: OP_NOP, cond: CND_DIV_BUSY, target: ST_DIV_WAIT};
         end
         ST_CHK_BOUND: begin
            w = '{in_ready: 1'b0, op: OP_NOP, cond: CND_D_GT_Q, target: ST_PRIME};
         end
         ST_CHK_REM: begin
            w = '{in_ready: 1'b0, op: OP_NOP, cond: CND_R_ZERO, target: ST_NOTPRIME};
         end
         ST_D_NEXT: begin
            w = '{in_ready: 1'b0, op: OP_D_ADD2, cond: CND_ALWAYS, target: ST_DIV_GO};
         end
         ST_PRIME: begin
            w = '{in_ready: 1'b0, op: OP_PF_SET, cond: CND_ALWAYS, target: ST_OUT_WAIT};
         end
         ST_NOTPRIME: begin
            w = '{in_ready: 1'b0, op: OP_PF_CLR, cond: CND_IS_TEST, target: ST_OUT_WAIT};
         end
         ST_SRCH_END: begin
            w = '{in_ready: 1'b0, op: OP_NOP, cond: CND_C_LT2, target: ST_SET_ONE};
         end
         ST_C_DEC: begin
            w = '{in_ready: 1'b0, op: OP_C_DEC, cond: CND_ALWAYS, target: ST_CHK_LT2};
         end
         ST_SET_ONE: begin
            w = '{in_ready: 1'b0, op: OP_C_ONE, cond: CND_ALWAYS, target: ST_OUT_WAIT};
         end
         ST_OUT_WAIT: begin
            w = '{in_ready: 1'b0, op: OP_NOP, cond: CND_OUT_FULL, target: ST_OUT_WAIT};
         end
         ST_EMIT: begin
            w = '{in_ready: 1'b0, op: OP_EMIT, cond: CND_ALWAYS, target: ST_FETCH};
         end
         default: begin
            w = '{in_ready: 1'b0, op: OP_NOP, cond: CND_ALWAYS, target: ST_FETCH};
         end
      endcase
      return w;
   endfunction

endpackage

/* src/ptsu_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on ptsu_pkg for the default operand width.
`timescale 1ns / 1ps

module ptsu_div
   import ptsu_pkg::*;
#(
   parameter int WIDTH = VALUE_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             busy,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [WIDTH:0]   rem_shift;
   logic             fits;

   // shift in the next dividend bit and try a subtract
   always_comb begin
      rem_shift = {rem_ff, quo_ff[WIDTH-1]};
      fits      = rem_shift >= {1'b0, dsr_ff};
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      if (start) begin
         cnt_in = CNT_W'(WIDTH);
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         quo_in = {quo_ff[WIDTH-2:0], fits};
         rem_in = fits ? WIDTH'(rem_shift - {1'b0, dsr_ff}) : rem_shift[WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = cnt_ff != '0;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* src/ptsu_seq.sv */
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on ptsu_pkg for the control word, status struct and ROM.
`timescale 1ns / 1ps

module ptsu_seq
   import ptsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output logic       in_ready,
   output op_type     op
);

   step_type  step_ff, step_in;
   cword_type cword;
   logic      take;

   // fetch the control word and resolve the jump
   always_comb begin
      cword = ucode_rom(step_ff);
      case (cword.cond)
         CND_NEVER:    take = 1'b0;
         CND_ALWAYS:   take = 1'b1;
         CND_NO_REQ:   take = !status.req_valid;
         CND_C_LT2:    take = status.c_lt2;
         CND_C_IS2:    take = status.c_is2;
         CND_C_EVEN:   take = status.c_even;
         CND_DIV_BUSY: take = status.div_busy;
         CND_D_GT_Q:   take = status.d_gt_q;
         CND_R_ZERO:   take = status.r_zero;
         CND_IS_TEST:  take = status.is_test;
         CND_OUT_FULL: take = status.out_full;
         default:      take = 1'b0;
      endcase
      step_in = take ? cword.target : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

   assign in_ready = cword.in_ready;
   assign op       = cword.op;

endmodule

/* src/prime_test_and_search_unit.sv */
// Top level of the prime test and search unit: datapath registers and stream ports.
// Depends on ptsu_pkg, ptsu_seq and ptsu_div.
`timescale 1ns / 1ps
//
//  channel | ports   | dir | payload
//  --------+---------+-----+--------------------------------------------
//  request | req_*   | in  | tdata: value; tuser: req_type (1 = search)
//  result  | rsp_*   | out | tdata: found_value; tuser: prime_flag
//
// One item at a time. Each trial divisor runs a full divide in the one-bit-per-cycle
// divider; a test takes up to about sqrt(value)/2 trials, a search repeats whole
// tests downward until a prime is found or the value drops below 2 (result 1, flag 0).
// Reset clears the step counter, the divider count and the result valid.
// The result register holds while rsp_tready is low; the next request is taken
// meanwhile, and its result waits in the datapath until the register frees.

module prime_test_and_search_unit
   import ptsu_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    req_tdata,  // value
   input  logic                                req_tuser,  // req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((VALUE_WIDTH+7)/8)*8-1:0]    rsp_tdata,  // found_value
   output logic                                rsp_tuser   // prime_flag
);

   localparam int W       = VALUE_WIDTH;
   localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

   logic [W-1:0] c_ff, c_in;
   logic [W-1:0] d_ff, d_in;
   logic         type_ff, type_in;
   logic         pf_ff, pf_in;
   logic [W-1:0] rsp_data_ff, rsp_data_in;
   logic         rsp_flag_ff, rsp_flag_in;
   logic         rsp_valid_ff, rsp_valid_in;

   op_type       op;
   status_type   status;
   logic         in_ready;
   logic         div_busy;
   logic [W-1:0] div_q, div_r;

   ptsu_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .status   (status),
      .in_ready (in_ready),
      .op       (op)
   );

   ptsu_div #(
      .WIDTH (W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (op == OP_DIV_GO),
      .dividend  (c_ff),
      .divisor   (d_ff),
      .busy      (div_busy),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // status flags for the jump conditions
   always_comb begin
      status.req_valid = req_tvalid;
      status.c_lt2     = c_ff < W'(2);
      status.c_is2     = c_ff == W'(2);
      status.c_even    = !c_ff[0];
      status.div_busy  = div_busy;
      status.d_gt_q    = d_ff > div_q;
      status.r_zero    = div_r == '0;
      status.is_test   = type_ff == REQ_TEST;
      status.out_full  = rsp_valid_ff && !rsp_tready;
   end

   // execute the datapath operation of this step
   always_comb begin
      c_in         = c_ff;
      d_in         = d_ff;
      type_in      = type_ff;
      pf_in        = pf_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (op)
         OP_LOAD: begin
            c_in    = req_tdata[W-1:0];
            type_in = req_tuser;
         end
         OP_D_INIT: d_in  = W'(3);
         OP_D_ADD2: d_in  = d_ff + W'(2);
         OP_PF_SET: pf_in = 1'b1;
         OP_PF_CLR: pf_in = 1'b0;
         OP_C_DEC:  c_in  = c_ff - W'(1);
         OP_C_ONE: begin
            c_in  = W'(1);
            pf_in = 1'b0;
         end
         OP_EMIT: begin
            rsp_data_in  = c_ff;
            rsp_flag_in  = pf_ff;
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      c_ff        <= c_in;
      d_ff        <= d_in;
      type_ff     <= type_in;
      pf_ff       <= pf_in;
      rsp_data_ff <= rsp_data_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign req_tready = in_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_flag_ff;

endmodule
